// ===== design/lrs_pkg.sv =====
// Shared widths, codes and types for the load-aware replica selector.
`default_nettype none

package lrs_pkg;

  localparam int unsigned CARRIED      = 4;   // replicas carried by one input beat
  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned TIME_W       = 48;
  localparam int unsigned SRV_W        = 4;
  localparam int unsigned CNT_W        = 32;
  localparam int unsigned CFG_W        = 32;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned DEF_REPLICAS = 4;
  localparam int unsigned DEF_SERVERS  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_STRATEGY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR = 2'd2;

  localparam logic [ADDR_W-1:0] OWN_ADDR_RST = 32'd1;

  typedef enum logic [1:0] {
    STRAT_NONE,
    STRAT_MIN_LOAD,
    STRAT_CORE_ONLY,
    STRAT_MIN_DIST
  } strategy_e;

  typedef enum logic [1:0] {
    LVL_HOST,
    LVL_EDGE,
    LVL_AGG,
    LVL_CORE
  } level_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DECAY,
    ST_MERGE,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic rd_en;
    logic el_en;
    logic dec_en;
    logic wr_en;
  } lane_ctl_t;

  typedef struct packed {
    logic [TIME_W-1:0] load;
    logic [TIME_W-1:0] stamp;
  } entry_t;

endpackage

`default_nettype wire

// ===== design/lrs_if.sv =====
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface lrs_in_if import lrs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [TIME_W-1:0] now_ns;
  logic [ADDR_W-1:0] dest_addr;
  logic [ADDR_W-1:0] replica_addr_0;
  logic [ADDR_W-1:0] replica_addr_1;
  logic [ADDR_W-1:0] replica_addr_2;
  logic [ADDR_W-1:0] replica_addr_3;
  logic [SRV_W-1:0]  replica_server_0;
  logic [SRV_W-1:0]  replica_server_1;
  logic [SRV_W-1:0]  replica_server_2;
  logic [SRV_W-1:0]  replica_server_3;
  logic [TIME_W-1:0] load_value;

  modport source (
    output valid, mode, now_ns, dest_addr,
           replica_addr_0, replica_addr_1, replica_addr_2, replica_addr_3,
           replica_server_0, replica_server_1, replica_server_2, replica_server_3,
           load_value,
    input  ready
  );
  modport sink (
    input  valid, mode, now_ns, dest_addr,
           replica_addr_0, replica_addr_1, replica_addr_2, replica_addr_3,
           replica_server_0, replica_server_1, replica_server_2, replica_server_3,
           load_value,
    output ready
  );
endinterface

interface lrs_out_if import lrs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] dest_out;
  logic              redirected;
  logic [CNT_W-1:0]  packet_count;
  logic [CNT_W-1:0]  redirect_count;

  modport source (
    output valid, dest_out, redirected, packet_count, redirect_count,
    input  ready
  );
  modport sink (
    input  valid, dest_out, redirected, packet_count, redirect_count,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/lrs_lane.sv =====
// One selection lane: a private copy of the load table plus the decay datapath.
`default_nettype none

module lrs_lane import lrs_pkg::*; #(
  parameter int unsigned SERVERS = DEF_SERVERS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lane_ctl_t         ctl_i,
  input  logic [SRV_W-1:0]  rd_srv_i,
  input  logic [SRV_W-1:0]  wr_srv_i,
  input  logic [TIME_W-1:0] now_i,
  input  logic [TIME_W-1:0] wr_load_i,
  output logic [TIME_W-1:0] load_o
);

  localparam int unsigned IDX_W = (SERVERS > 1) ? $clog2(SERVERS) : 1;

  entry_t            mem_q [SERVERS];
  logic [SERVERS-1:0] valid_q;

  logic [IDX_W-1:0]  rd_idx, wr_idx;
  logic              rd_in_range, wr_in_range;
  entry_t            ent_q;
  logic              ok_q;
  logic [TIME_W-1:0] load_eff, stamp_eff;
  logic [TIME_W-1:0] el_q, ld_q, dec_q;

  assign rd_idx      = IDX_W'(rd_srv_i);
  assign wr_idx      = IDX_W'(wr_srv_i);
  assign rd_in_range = 32'(rd_srv_i) < SERVERS;
  assign wr_in_range = 32'(wr_srv_i) < SERVERS;

  // table write; every lane copy takes the same write
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en && wr_in_range) begin
      mem_q[wr_idx] <= '{load: wr_load_i, stamp: now_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.wr_en && wr_in_range) begin
      valid_q[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      ent_q <= mem_q[rd_idx];
      ok_q  <= rd_in_range && valid_q[rd_idx];
    end
  end

  // unwritten or out-of-range entries read as zero load, zero stamp
  assign load_eff  = ok_q ? ent_q.load  : '0;
  assign stamp_eff = ok_q ? ent_q.stamp : '0;

  always_ff @(posedge clk_i) begin
    if (ctl_i.el_en) begin
      el_q <= now_i - stamp_eff;   // wraps modulo 2^48
      ld_q <= load_eff;
    end
    if (ctl_i.dec_en) begin
      dec_q <= (el_q < ld_q) ? (ld_q - el_q) : '0;
    end
  end

  assign load_o = dec_q;

endmodule

`default_nettype wire

// ===== design/lrs_merge.sv =====
// Merge stage: registered least-load pick over the used lanes, first lane wins a tie; no used lane gives dest.
`default_nettype none

module lrs_merge import lrs_pkg::*; #(
  parameter int unsigned LANES = CARRIED
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [TIME_W-1:0] load_i [LANES],
  input  logic [LANES-1:0]  use_i,
  input  logic [ADDR_W-1:0] addr_i [LANES],
  input  logic [ADDR_W-1:0] dest_i,
  output logic [ADDR_W-1:0] best_addr_o
);

  logic [TIME_W-1:0] pl [CARRIED];
  logic [ADDR_W-1:0] pa [CARRIED];
  logic [CARRIED-1:0] pu;

  logic              s01, s23, sf;
  logic [TIME_W-1:0] la, lb;
  logic [ADDR_W-1:0] aa, ab;
  logic              ua, ub;
  logic [ADDR_W-1:0] best_d, best_q;

  always_comb begin
    for (int i = 0; i < CARRIED; i++) begin
      if (i < LANES) begin
        pl[i] = load_i[i];
        pa[i] = addr_i[i];
        pu[i] = use_i[i];
      end else begin
        pl[i] = '0;
        pa[i] = '0;
        pu[i] = 1'b0;
      end
    end
  end

  always_comb begin
    s01 = pu[1] && (!pu[0] || (pl[1] < pl[0]));
    s23 = pu[3] && (!pu[2] || (pl[3] < pl[2]));
    la  = s01 ? pl[1] : pl[0];
    aa  = s01 ? pa[1] : pa[0];
    ua  = pu[0] || pu[1];
    lb  = s23 ? pl[3] : pl[2];
    ab  = s23 ? pa[3] : pa[2];
    ub  = pu[2] || pu[3];
    sf  = ub && (!ua || (lb < la));
    if (ua || ub) begin
      best_d = sf ? ab : aa;
    end else begin
      best_d = dest_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      best_q <= best_d;
    end
  end

  assign best_addr_o = best_q;

endmodule

`default_nettype wire

// ===== design/load_aware_replica_selector.sv =====
// Top level of the load-aware replica selector: control, lanes and merge.
//
//  channel  dir  handshake      payload
//  in_i     in   valid / ready  mode, now_ns, dest_addr, replica_addr_*, replica_server_*,
//                               load_value
//  out_o    out  valid / ready  dest_out, redirected, packet_count, redirect_count
//  cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// A packet goes from accept through read, elapsed, decay, merge, one table write step per
// lane and result; a load write takes a single table write before its result. The write-back
// sweep is set by the single write port of each lane's table copy.
// Reset clears the table valid bits, counters and control and sets config to its defaults.
// A result stalled on out_o holds the block in its last state; one new beat is
// accepted while an earlier result waits.
`default_nettype none

module load_aware_replica_selector import lrs_pkg::*; #(
  parameter int unsigned REPLICAS = DEF_REPLICAS,
  parameter int unsigned SERVERS  = DEF_SERVERS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  lrs_in_if.sink               in_i,
  lrs_out_if.source            out_o
);

  localparam int unsigned LANES = (REPLICAS < CARRIED) ? REPLICAS : CARRIED;
  localparam int unsigned WI_W  = (LANES > 1) ? $clog2(LANES) : 1;

  strategy_e         strategy_q;
  level_e            level_q;
  logic [ADDR_W-1:0] own_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strategy_q <= STRAT_NONE;
      level_q    <= LVL_HOST;
      own_q      <= OWN_ADDR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STRATEGY: strategy_q <= strategy_e'(cfg_data_i[1:0]);
        CFG_LEVEL:    level_q    <= level_e'(cfg_data_i[1:0]);
        CFG_OWN_ADDR: own_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [ADDR_W-1:0] in_addr [CARRIED];
  logic [SRV_W-1:0]  in_srv  [CARRIED];

  assign in_addr[0] = in_i.replica_addr_0;
  assign in_addr[1] = in_i.replica_addr_1;
  assign in_addr[2] = in_i.replica_addr_2;
  assign in_addr[3] = in_i.replica_addr_3;
  assign in_srv[0]  = in_i.replica_server_0;
  assign in_srv[1]  = in_i.replica_server_1;
  assign in_srv[2]  = in_i.replica_server_2;
  assign in_srv[3]  = in_i.replica_server_3;

  state_e            state_q, state_d;
  logic [WI_W-1:0]   wr_idx_q, wr_idx_d;
  logic              accept, emit, last_wr, wr_hit, redir;

  logic              mode_q;
  logic [TIME_W-1:0] now_q, load_val_q;
  logic [ADDR_W-1:0] dest_q;
  logic [ADDR_W-1:0] addr_q [LANES];
  logic [SRV_W-1:0]  srv_q  [LANES];
  logic [LANES-1:0]  use_q, use_d, near;

  logic              out_valid_q;
  logic [ADDR_W-1:0] dest_out_q;
  logic              redir_out_q;
  logic [CNT_W-1:0]  pkt_cnt_q, red_cnt_q;

  lane_ctl_t         ctl;
  logic [TIME_W-1:0] lane_load [LANES];
  logic [ADDR_W-1:0] best_addr;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // distance filter: edge matches octet 1, aggregation octet 2
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      case (level_q)
        LVL_EDGE: near[l] = in_addr[l][15:8]  == own_q[15:8];
        LVL_AGG:  near[l] = in_addr[l][23:16] == own_q[23:16];
        LVL_CORE: near[l] = 1'b1;
        default:  near[l] = 1'b0;
      endcase
    end
    if (strategy_q == STRAT_MIN_DIST && (|near)) begin
      use_d = near;
    end else begin
      use_d = '1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q     <= in_i.mode;
      now_q      <= in_i.now_ns;
      dest_q     <= in_i.dest_addr;
      load_val_q <= in_i.load_value;
      use_q      <= use_d;
      for (int l = 0; l < LANES; l++) begin
        addr_q[l] <= in_addr[l];
        srv_q[l]  <= in_srv[l];
      end
    end
  end

  // write-back sweep: a load write uses slot 0 only
  assign wr_hit  = mode_q || ((strategy_q != STRAT_NONE) && use_q[wr_idx_q]);
  assign last_wr = mode_q || (wr_idx_q == WI_W'(LANES - 1));
  assign emit    = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    ctl.rd_en  = accept;
    ctl.el_en  = (state_q == ST_READ);
    ctl.dec_en = (state_q == ST_DECAY);
    ctl.wr_en  = (state_q == ST_WRITE) && wr_hit;
    state_d    = state_q;
    wr_idx_d   = wr_idx_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d  = in_i.mode ? ST_WRITE : ST_READ;
          wr_idx_d = '0;
        end
      end
      ST_READ:  state_d = ST_DECAY;
      ST_DECAY: state_d = ST_MERGE;
      ST_MERGE: state_d = ST_WRITE;
      ST_WRITE: begin
        if (last_wr) begin
          state_d = ST_DONE;
        end else begin
          wr_idx_d = wr_idx_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (emit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wr_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      wr_idx_q <= wr_idx_d;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    lrs_lane #(
      .SERVERS (SERVERS)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .rd_srv_i  (in_srv[g]),
      .wr_srv_i  (srv_q[wr_idx_q]),
      .now_i     (now_q),
      .wr_load_i (mode_q ? load_val_q : lane_load[wr_idx_q]),
      .load_o    (lane_load[g])
    );
  end

  lrs_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk_i       (clk_i),
    .en_i        (state_q == ST_MERGE),
    .load_i      (lane_load),
    .use_i       (use_q),
    .addr_i      (addr_q),
    .dest_i      (dest_q),
    .best_addr_o (best_addr)
  );

  assign redir = !mode_q && (strategy_q != STRAT_NONE) && (best_addr != dest_q) &&
                 ((strategy_q != STRAT_CORE_ONLY) || (level_q == LVL_CORE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pkt_cnt_q   <= '0;
      red_cnt_q   <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        if (!mode_q) begin
          pkt_cnt_q <= pkt_cnt_q + 1'b1;
        end
        if (redir) begin
          red_cnt_q <= red_cnt_q + 1'b1;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      dest_out_q  <= mode_q ? '0 : (redir ? best_addr : dest_q);
      redir_out_q <= redir;
    end
  end

  // counters only move when the next beat is loaded, so they serve as payload
  assign out_o.valid          = out_valid_q;
  assign out_o.dest_out       = dest_out_q;
  assign out_o.redirected     = redir_out_q;
  assign out_o.packet_count   = pkt_cnt_q;
  assign out_o.redirect_count = red_cnt_q;

`ifndef SYNTHESIS
  a_pkt_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !mode_q |=> pkt_cnt_q == $past(pkt_cnt_q) + 1'b1)
    else $error("packet counter did not step on a packet result");

  a_load_write_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && mode_q |=> (pkt_cnt_q == $past(pkt_cnt_q)) && (red_cnt_q == $past(red_cnt_q)))
    else $error("load write changed a counter");

  a_wr_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE |-> 32'(wr_idx_q) < LANES)
    else $error("write sweep index beyond lane count");
`endif

endmodule

`default_nettype wire
